### sv/gcsat_pkg.sv
`timescale 1ns / 1ps

package gcsat_pkg;

   // Default grid limits for the top level parameters.
   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;

   // Widths fixed by the item fields.
   localparam int CFG_W   = 7;
   localparam int RECT_W  = 6;
   localparam int TOTAL_W = 12;

   // Configuration register indexes and their reset values.
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;
   localparam logic [CFG_W-1:0] RESET_ROWS = 7'd64;
   localparam logic [CFG_W-1:0] RESET_COLS = 7'd64;

   // Queue depths, as log2 of the entry count.
   localparam int CMD_QUEUE_LOG = 2;
   localparam int RSP_QUEUE_LOG = 1;

   // One result item as it leaves the back end.
   typedef struct packed {
      logic [TOTAL_W-1:0] ground_total;
      logic               bad_query;
   } rsp_item_type;

endpackage

### sv/ground_count_summed_area_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_push / req_full  kind, is_ground, rect_top, rect_left,
//                                           rect_height, rect_width
// rsp_      out        rsp_empty / rsp_pop  ground_total, bad_query
// csr_      in         csr_valid / csr_ready csr_index, csr_data
//
// Cell items pass the back end at one per cycle while no query or clearing pass holds them.
// A query makes four corner reads through the single table read port, then
// combines them into the result queue.
// After reset a clearing pass over all MAX_ROWS * MAX_COLS entries (4096 by default)
// zeroes the table; req_full stays high for it, csr writes are taken as usual.
// A four-entry command queue lets cells keep streaming while a query runs;
// a two-entry result queue holds up to two results before queries stall.

module ground_count_summed_area_table
   import gcsat_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_kind,
   input  logic               req_is_ground,
   input  logic [RECT_W-1:0]  req_rect_top,
   input  logic [RECT_W-1:0]  req_rect_left,
   input  logic [RECT_W-1:0]  req_rect_height,
   input  logic [RECT_W-1:0]  req_rect_width,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [TOTAL_W-1:0] rsp_ground_total,
   output logic               rsp_bad_query,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [CFG_W-1:0]   csr_data
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int EW = 2 + 2 * RW + 3 * CW;

   logic          cmd_push;
   logic [EW-1:0] cmd_in_data;
   logic          cmd_full;
   logic          cmd_pop;
   logic [EW-1:0] cmd_out_data;
   logic          cmd_empty;
   logic          clearing;
   logic          out_push;
   rsp_item_type  out_item;
   logic          out_full;
   rsp_item_type  rsp_head;

   // Input is held off while the command queue is full or the table clears.
   assign req_full = cmd_full || clearing;

   gcsat_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .EW       (EW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_is_ground   (req_is_ground),
      .req_rect_top    (req_rect_top),
      .req_rect_left   (req_rect_left),
      .req_rect_height (req_rect_height),
      .req_rect_width  (req_rect_width),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in_data)
   );

   gcsat_queue #(
      .W   (EW),
      .LOG (CMD_QUEUE_LOG)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   gcsat_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .EW       (EW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .out_push  (out_push),
      .out_item  (out_item),
      .out_full  (out_full)
   );

   gcsat_queue #(
      .W   ($bits(rsp_item_type)),
      .LOG (RSP_QUEUE_LOG)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_ground_total = rsp_head.ground_total;
   assign rsp_bad_query    = rsp_head.bad_query;

endmodule

### sv/gcsat_queue.sv
`timescale 1ns / 1ps

module gcsat_queue #(
   parameter int W   = 1,
   parameter int LOG = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int N = 2 ** LOG;

   logic [W-1:0]   slot_ff [N];
   logic [LOG-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LOG-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LOG:0]   count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign full     = (count_ff == (LOG + 1)'(N));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   // The fill count never runs past the number of entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (LOG + 1)'(N))
      else $error("queue fill count exceeds depth");

   // A lone push raises the count by one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");
`endif

endmodule

### sv/gcsat_front.sv
`timescale 1ns / 1ps

module gcsat_front
   import gcsat_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int RW       = $clog2(MAX_ROWS),
   parameter int CW       = $clog2(MAX_COLS),
   parameter int EW       = 2 + 2 * RW + 3 * CW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic              req_kind,
   input  logic              req_is_ground,
   input  logic [RECT_W-1:0] req_rect_top,
   input  logic [RECT_W-1:0] req_rect_left,
   input  logic [RECT_W-1:0] req_rect_height,
   input  logic [RECT_W-1:0] req_rect_width,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_data,
   output logic              cmd_push,
   output logic [EW-1:0]     cmd_data
);

   // Wide enough for grid sizes, positions plus one and rectangle sums.
   localparam int MW = (RW > CW) ? RW : CW;
   localparam int PW = ((MW > CFG_W) ? MW : CFG_W) + 1;

   // Command layout shared with the back end.
   typedef struct packed {
      logic          is_query;
      logic          bad;
      logic [RW-1:0] row_a;
      logic [RW-1:0] row_b;
      logic [CW-1:0] col_a;
      logic [CW-1:0] col_b;
      logic [CW-1:0] rsum;
   } cmd_type;

   logic [CFG_W-1:0] rows_cfg_ff;
   logic [CFG_W-1:0] cols_cfg_ff;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    rsum_ff, rsum_in;
   logic [PW-1:0]    rows_x;
   logic [PW-1:0]    cols_x;
   logic             pos_wrap;
   logic [RW-1:0]    cur_row;
   logic [CW-1:0]    cur_col;
   logic             cell_wr;
   logic             accept;
   logic             query_bad;
   logic [PW-1:0]    bottom_x;
   logic [PW-1:0]    right_x;
   cmd_type          cmd;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= RESET_ROWS;
         cols_cfg_ff <= RESET_COLS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROWS: rows_cfg_ff <= csr_data;
            REG_COLS: cols_cfg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Grid sizes in use, held between two and the table limits.
   always_comb begin
      if (rows_cfg_ff < CFG_W'(2)) begin
         rows_x = PW'(2);
      end else if (PW'(rows_cfg_ff) > PW'(MAX_ROWS)) begin
         rows_x = PW'(MAX_ROWS);
      end else begin
         rows_x = PW'(rows_cfg_ff);
      end
      if (cols_cfg_ff < CFG_W'(2)) begin
         cols_x = PW'(2);
      end else if (PW'(cols_cfg_ff) > PW'(MAX_COLS)) begin
         cols_x = PW'(MAX_COLS);
      end else begin
         cols_x = PW'(cols_cfg_ff);
      end
   end

   // Load position of this cell; a position off the grid restarts at the corner.
   always_comb begin
      pos_wrap = (PW'(row_ff) >= rows_x) || (PW'(col_ff) >= cols_x);
      cur_row  = pos_wrap ? '0 : row_ff;
      cur_col  = pos_wrap ? '0 : col_ff;
      cell_wr  = (cur_row != '0) && (cur_col != '0);
   end

   // Running row sum and raster advance on each accepted cell.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      rsum_in = rsum_ff;
      if (accept && !req_kind) begin
         if (cur_col == '0) begin
            rsum_in = '0;
         end else if (cell_wr) begin
            rsum_in = rsum_ff + CW'(req_is_ground);
         end
         if (PW'(cur_col) + PW'(1) >= cols_x) begin
            col_in = '0;
            row_in = (PW'(cur_row) + PW'(1) >= rows_x) ? '0 : cur_row + 1'b1;
         end else begin
            col_in = cur_col + 1'b1;
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         rsum_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         rsum_ff <= rsum_in;
      end
   end

   // Rectangle check against the grid in use.
   always_comb begin
      bottom_x  = PW'(req_rect_top) + PW'(req_rect_height);
      right_x   = PW'(req_rect_left) + PW'(req_rect_width);
      query_bad = (req_rect_top == '0) || (req_rect_left == '0) ||
                  (bottom_x > rows_x) || (right_x > cols_x);
   end

   // Command build: a cell names its entry, a query its four corners.
   always_comb begin
      cmd = '0;
      if (req_kind) begin
         cmd.is_query = 1'b1;
         cmd.bad      = query_bad;
         if (!query_bad) begin
            cmd.row_a = RW'(bottom_x - PW'(1));
            cmd.row_b = RW'(req_rect_top - 1'b1);
            cmd.col_a = CW'(right_x - PW'(1));
            cmd.col_b = CW'(req_rect_left - 1'b1);
         end
      end else begin
         cmd.row_a = cur_row;
         cmd.col_a = cur_col;
         cmd.rsum  = rsum_in;
      end
   end

   // Border cells write nothing and need no back end work.
   assign cmd_push = accept && (req_kind || cell_wr);
   assign cmd_data = cmd;

endmodule

### sv/gcsat_back.sv
`timescale 1ns / 1ps

module gcsat_back
   import gcsat_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int RW       = $clog2(MAX_ROWS),
   parameter int CW       = $clog2(MAX_COLS),
   parameter int EW       = 2 + 2 * RW + 3 * CW
) (
   input  logic         clock,
   input  logic         reset,
   output logic         clearing,
   input  logic         cmd_empty,
   input  logic [EW-1:0] cmd_data,
   output logic         cmd_pop,
   output logic         out_push,
   output rsp_item_type out_item,
   input  logic         out_full
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] STEP_FIRST = 2'd0;
   localparam logic [1:0] STEP_LAST  = 2'd3;

   typedef struct packed {
      logic          is_query;
      logic          bad;
      logic [RW-1:0] row_a;
      logic [RW-1:0] row_b;
      logic [CW-1:0] col_a;
      logic [CW-1:0] col_b;
      logic [CW-1:0] rsum;
   } cmd_type;

   logic [TOTAL_W-1:0] table_mem [DEPTH];
   logic [TOTAL_W-1:0] rdata_ff;
   logic [AW-1:0]      raddr;
   logic               we;
   logic [AW-1:0]      waddr;
   logic [TOTAL_W-1:0] wdata;

   logic               clear_ff, clear_in;
   logic [AW-1:0]      clear_addr_ff, clear_addr_in;
   logic [1:0]         step_ff, step_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_query_ff;
   logic [1:0]         s2_step_ff;
   logic               s2_bad_ff;
   logic [AW-1:0]      s2_waddr_ff;
   logic [CW-1:0]      s2_rsum_ff;
   logic [TOTAL_W-1:0] acc_ff, acc_in;

   cmd_type            head;
   logic               pending;
   logic               issue_cell;
   logic               issue_query;
   logic [RW-1:0]      sel_row;
   logic [CW-1:0]      sel_col;

   function automatic logic [AW-1:0] tab_addr(logic [RW-1:0] r, logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_COLS) + AW'(c);
   endfunction

   assign head     = cmd_type'(cmd_data);
   assign clearing = clear_ff;

   // Clearing pass over the whole table after reset.
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // Issue: a cell reads the entry above; a query reads one corner per cycle.
   always_comb begin
      pending     = (step_ff != STEP_FIRST) || (s2_valid_ff && s2_query_ff);
      issue_cell  = !clear_ff && !cmd_empty && !head.is_query;
      issue_query = !clear_ff && !cmd_empty && head.is_query &&
                    ((step_ff != STEP_FIRST) || (!out_full && !pending));
      cmd_pop     = issue_cell || (issue_query && (step_ff == STEP_LAST));
      step_in     = issue_query ? step_ff + 1'b1 : step_ff;
      s2_valid_in = issue_cell || issue_query;
      sel_row     = step_ff[0] ? head.row_b : head.row_a;
      sel_col     = step_ff[1] ? head.col_b : head.col_a;
      if (issue_cell) begin
         raddr = tab_addr(head.row_a - 1'b1, head.col_a);
      end else begin
         raddr = tab_addr(sel_row, sel_col);
      end
   end

   // Write port: clearing pass, or a cell entry in the cycle after its read.
   always_comb begin
      if (clear_ff) begin
         we    = 1'b1;
         waddr = clear_addr_ff;
         wdata = '0;
      end else begin
         we    = s2_valid_ff && !s2_query_ff;
         waddr = s2_waddr_ff;
         wdata = rdata_ff + TOTAL_W'(s2_rsum_ff);
      end
   end

   // Table memory; a read of the entry being written sees the new value.
   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= wdata;
      end
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= table_mem[raddr];
      end
   end

   // Corner combination: plus, minus, minus, plus, modulo the entry width.
   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff && s2_query_ff) begin
         if (s2_step_ff == STEP_FIRST) begin
            acc_in = rdata_ff;
         end else if (s2_step_ff != STEP_LAST) begin
            acc_in = acc_ff - rdata_ff;
         end
      end
      out_push              = s2_valid_ff && s2_query_ff && (s2_step_ff == STEP_LAST);
      out_item.bad_query    = s2_bad_ff;
      out_item.ground_total = s2_bad_ff ? '0 : acc_ff + rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         step_ff       <= STEP_FIRST;
         s2_valid_ff   <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         step_ff       <= step_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   // Second stage payload.
   always_ff @(posedge clock) begin
      s2_query_ff <= head.is_query;
      s2_step_ff  <= step_ff;
      s2_bad_ff   <= head.bad;
      s2_waddr_ff <= tab_addr(head.row_a, head.col_a);
      s2_rsum_ff  <= head.rsum;
      acc_ff      <= acc_in;
   end

`ifndef NO_ASSERTIONS
   // No command leaves the queue while the table is being cleared.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !cmd_pop)
      else $error("command taken during clearing pass");

   // A result is only produced when the result queue has room.
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result produced into a full queue");

   // A query's four reads are issued in consecutive cycles.
   a_query_run: assert property (@(posedge clock) disable iff (reset)
      (issue_query && (step_ff != STEP_LAST)) |=> issue_query)
      else $error("query read sequence broken");

   // No cell write competes with the clearing pass.
   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(s2_valid_ff && !s2_query_ff))
      else $error("cell write during clearing pass");
`endif

endmodule

### tb/tb_ground_count_summed_area_table.sv
`timescale 1ns / 1ps

module tb_ground_count_summed_area_table;
   import gcsat_pkg::*;

   localparam int MAX_ROWS     = DEFAULT_MAX_ROWS;
   localparam int MAX_COLS     = DEFAULT_MAX_COLS;
   localparam int FULL_SIDE    = 12;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   // Item kinds on the request channel.
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic              kind;
      logic              is_ground;
      logic [RECT_W-1:0] top;
      logic [RECT_W-1:0] left;
      logic [RECT_W-1:0] height;
      logic [RECT_W-1:0] width;
   } grid_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_kind = KIND_CELL;
   logic               req_is_ground = 1'b0;
   logic [RECT_W-1:0]  req_rect_top = '0;
   logic [RECT_W-1:0]  req_rect_left = '0;
   logic [RECT_W-1:0]  req_rect_height = '0;
   logic [RECT_W-1:0]  req_rect_width = '0;
   logic               rsp_pop = 1'b0;
   logic               csr_valid = 1'b0;
   logic               csr_index = REG_ROWS;
   logic [CFG_W-1:0]   csr_data = '0;
   logic               req_full;
   logic               rsp_empty;
   logic [TOTAL_W-1:0] rsp_ground_total;
   logic               rsp_bad_query;
   logic               csr_ready;

   ground_count_summed_area_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_is_ground    (req_is_ground),
      .req_rect_top     (req_rect_top),
      .req_rect_left    (req_rect_left),
      .req_rect_height  (req_rect_height),
      .req_rect_width   (req_rect_width),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_ground_total (rsp_ground_total),
      .rsp_bad_query    (rsp_bad_query),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Predicted copy of the block: table, load position and size registers.
   logic [TOTAL_W-1:0] ground_sums [MAX_ROWS*MAX_COLS];
   int unsigned        row_sum;
   int unsigned        next_row;
   int unsigned        next_col;
   logic [CFG_W-1:0]   rows_setting;
   logic [CFG_W-1:0]   cols_setting;
   rsp_item_type       pending_counts [$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic int unsigned used_rows();
      return clamp_dim(rows_setting, MAX_ROWS);
   endfunction

   function automatic int unsigned used_cols();
      return clamp_dim(cols_setting, MAX_COLS);
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_at(input int unsigned r, input int unsigned c);
      return ground_sums[r*MAX_COLS + c];
   endfunction

   task automatic reset_prediction();
      foreach (ground_sums[i]) ground_sums[i] = '0;
      row_sum      = 0;
      next_row     = 0;
      next_col     = 0;
      rows_setting = RESET_ROWS;
      cols_setting = RESET_COLS;
   endtask

   // Advance the predicted table by one accepted item; queries queue a count.
   task automatic predict_ground_count(input grid_item_type it);
      int unsigned        rows;
      int unsigned        cols;
      int unsigned        bottom;
      int unsigned        right;
      int unsigned        top_i;
      int unsigned        left_i;
      int unsigned        height_i;
      int unsigned        width_i;
      rsp_item_type       res;
      rows = used_rows();
      cols = used_cols();
      if (it.kind == KIND_CELL) begin
         // A position left outside a shrunken grid restarts at the corner.
         if (next_row >= rows || next_col >= cols) begin
            next_row = 0;
            next_col = 0;
         end
         if (next_col == 0) row_sum = 0;
         if (next_row != 0 && next_col != 0) begin
            row_sum += 32'(it.is_ground);
            ground_sums[next_row*MAX_COLS + next_col] =
               sat_at(next_row - 1, next_col) + TOTAL_W'(row_sum);
         end
         next_col++;
         if (next_col >= cols) begin
            next_col = 0;
            next_row++;
            if (next_row >= rows) next_row = 0;
         end
      end else begin
         top_i    = 32'(it.top);
         left_i   = 32'(it.left);
         height_i = 32'(it.height);
         width_i  = 32'(it.width);
         res.ground_total = '0;
         res.bad_query    = 1'b0;
         if (top_i == 0 || left_i == 0 || top_i + height_i > rows ||
             left_i + width_i > cols) begin
            res.bad_query = 1'b1;
         end else begin
            bottom = top_i + height_i - 1;
            right  = left_i + width_i - 1;
            res.ground_total = sat_at(bottom, right) - sat_at(top_i - 1, right)
                               - sat_at(bottom, left_i - 1) + sat_at(top_i - 1, left_i - 1);
         end
         pending_counts = {pending_counts, res};
      end
   endtask

   function automatic grid_item_type make_cell(input logic ground);
      grid_item_type it;
      it.kind      = KIND_CELL;
      it.is_ground = ground;
      it.top       = RECT_W'($urandom_range(0, 63));
      it.left      = RECT_W'($urandom_range(0, 63));
      it.height    = RECT_W'($urandom_range(0, 63));
      it.width     = RECT_W'($urandom_range(0, 63));
      return it;
   endfunction

   function automatic grid_item_type make_query(input int unsigned t, input int unsigned l,
                                                input int unsigned h, input int unsigned w);
      grid_item_type it;
      it.kind      = KIND_QUERY;
      it.is_ground = 1'($urandom_range(0, 1));
      it.top       = RECT_W'(t);
      it.left      = RECT_W'(l);
      it.height    = RECT_W'(h);
      it.width     = RECT_W'(w);
      return it;
   endfunction

   // Mostly rectangles inside the grid, the rest arbitrary field values.
   function automatic grid_item_type random_query();
      int unsigned rows;
      int unsigned cols;
      int unsigned t;
      int unsigned l;
      rows = used_rows();
      cols = used_cols();
      if ($urandom_range(0, 4) == 0)
         return make_query($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom_range(0, 63));
      t = $urandom_range(1, rows - 1);
      l = $urandom_range(1, cols - 1);
      return make_query(t, l, $urandom_range(0, rows - t), $urandom_range(0, cols - l));
   endfunction

   // Mostly small grids, sometimes up to the largest, now and then raw register values.
   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return CFG_W'($urandom_range(0, 127));
         1: return CFG_W'($urandom_range(2, 64));
         default: return CFG_W'($urandom_range(2, 10));
      endcase
   endfunction

   // Offer one item, with a random gap first, and predict it once it is taken.
   task automatic send_item(input grid_item_type it);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_push        <= 1'b1;
      req_kind        <= it.kind;
      req_is_ground   <= it.is_ground;
      req_rect_top    <= it.top;
      req_rect_left   <= it.left;
      req_rect_height <= it.height;
      req_rect_width  <= it.width;
      do @(posedge clock); while (req_full);
      predict_ground_count(it);
   endtask

   // Hold off input until every count has come back and the cell pipeline is empty.
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both size registers back to back; only called while the block is idle.
   task automatic configure_grid(input logic [CFG_W-1:0] rows_val,
                                 input logic [CFG_W-1:0] cols_val);
      csr_valid <= 1'b1;
      csr_index <= REG_ROWS;
      csr_data  <= rows_val;
      do @(posedge clock); while (!csr_ready);
      rows_setting = rows_val;
      csr_index <= REG_COLS;
      csr_data  <= cols_val;
      do @(posedge clock); while (!csr_ready);
      cols_setting = cols_val;
      csr_valid <= 1'b0;
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("Mismatch on %s: expected %0d, got %0d", field, want, got);
   endtask

   // Random receiver stalls.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
   end

   // Compare each accepted result with the oldest predicted count.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("Result with no query waiting: total %0d, bad %0d",
                        rsp_ground_total, rsp_bad_query);
         end else begin
            want = pending_counts.pop_front();
            if (rsp_ground_total !== want.ground_total)
               note_mismatch("ground_total", 32'(want.ground_total), 32'(rsp_ground_total));
            if (rsp_bad_query !== want.bad_query)
               note_mismatch("bad_query", 32'(want.bad_query), 32'(rsp_bad_query));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Queries against the cleared table at the reset sizes, including rejects.
   task automatic test_empty_table();
      send_item(make_query(1, 1, 63, 63));
      send_item(make_query(63, 63, 1, 1));
      send_item(make_query(1, 1, 0, 0));
      send_item(make_query(0, 5, 3, 3));
      send_item(make_query(5, 0, 3, 3));
      send_item(make_query(63, 63, 63, 63));
      wait_for_results();
   endtask

   // Sizes below the minimum clamp to 2 x 2; only one cell is ever counted.
   task automatic test_smallest_grid();
      configure_grid('0, CFG_W'(1));
      repeat (4) send_item(make_cell(1'b1));
      send_item(make_query(1, 1, 1, 1));
      send_item(make_query(1, 1, 1, 2));
      send_item(make_query(1, 1, 2, 1));
      // The grid wraps and the next pass overwrites the table.
      repeat (4) send_item(make_cell(1'b0));
      send_item(make_query(1, 1, 1, 1));
      wait_for_results();
   endtask

   // A new grid partly over an old one makes the corner sum wrap.
   task automatic test_wrapped_total();
      configure_grid(CFG_W'(3), CFG_W'(3));
      repeat (9) send_item(make_cell(1'b0));
      repeat (5) send_item(make_cell(1'b1));
      send_item(make_query(2, 1, 1, 1));
      send_item(make_query(1, 1, 2, 2));
      wait_for_results();
   endtask

   // Shrinking the grid mid-load keeps a position still inside it; rewriting sizes keeps the table.
   task automatic test_shrink_mid_load();
      configure_grid(CFG_W'(4), CFG_W'(4));
      repeat (5) send_item(make_cell(1'b1));
      wait_for_results();
      configure_grid(CFG_W'(4), CFG_W'(2));
      send_item(make_query(1, 1, 3, 1));
      repeat (3) send_item(make_cell(1'b1));
      send_item(make_query(1, 1, 3, 1));
      wait_for_results();
      configure_grid(CFG_W'(4), CFG_W'(2));
      send_item(make_query(1, 1, 3, 1));
      wait_for_results();
   endtask

   // Register values above the maximum clamp to 64.
   task automatic test_size_register_extremes();
      configure_grid('1, '1);
      send_item(make_query(1, 1, 63, 63));
      send_item(make_query(2, 2, 62, 62));
      send_item(make_query(2, 2, 63, 62));
      wait_for_results();
   endtask

   // Load one whole grid of ground cells and count over all of it.
   task automatic test_full_grid();
      int loaded;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      configure_grid(CFG_W'(FULL_SIDE), CFG_W'(FULL_SIDE));
      loaded = 0;
      do begin
         send_item(make_cell(1'b1));
         loaded++;
      end while (loaded < FULL_SIDE * FULL_SIDE || next_row != 0 || next_col != 0);
      send_item(make_query(1, 1, FULL_SIDE - 1, FULL_SIDE - 1));
      send_item(make_query(FULL_SIDE / 2, FULL_SIDE / 2, FULL_SIDE / 2, FULL_SIDE / 2));
      send_item(make_query(1, 1, FULL_SIDE - 1, 1));
      wait_for_results();
   endtask

   // Random grids with queries mixed into the cell stream.
   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
      int          sent;
      int unsigned grid_cells;
      int unsigned to_load;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         wait_for_results();
         configure_grid(pick_size(), pick_size());
         grid_cells = used_rows() * used_cols();
         to_load = grid_cells;
         if (grid_cells > 300 || $urandom_range(0, 3) == 0)
            to_load = $urandom_range(1, (grid_cells > 300) ? 300 : grid_cells);
         for (int unsigned k = 0; k < to_load; k++) begin
            if ($urandom_range(0, 3) == 0) send_item(random_query());
            else send_item(make_cell(1'($urandom_range(0, 1))));
            sent++;
            // Now and then the sender waits for every count to come back.
            if ($urandom_range(0, 63) == 0) wait_for_results();
         end
         repeat ($urandom_range(1, 3)) begin
            send_item(random_query());
            sent++;
         end
      end
      wait_for_results();
   endtask

   initial begin
      reset_prediction();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_smallest_grid();
      test_wrapped_total();
      test_shrink_mid_load();
      test_size_register_extremes();
      test_full_grid();
      run_random_phase(0, 0, 200);
      run_random_phase(46, 0, 200);
      run_random_phase(0, 46, 200);
      run_random_phase(36, 36, 200);
      wait_for_results();
      if (mismatches == 0 && pending_counts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
